// ===== rtl/core/tmi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmi_pkg
// Shared types, codes and the microcode store of the tape machine interpreter.
// ----------------------------------------------------------------------------
package tmi_pkg;

	// default geometry of the shared program and data store
	localparam int MEM_DEPTH_DEF  = 512;
	localparam int WORD_WIDTH_DEF = 32;

	// fixed widths of the channel fields
	localparam int CMD_ADDR_W = 9;
	localparam int OUT_W      = 32;

	// the multiplier is a 32 x 32 unit, wider words go through partial products
	localparam int MUL_W  = 32;
	localparam int PROD_W = 2 * MUL_W;

	// request opcodes
	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_STEP  = 2'd1,
		CMD_READ  = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_op_e;

	// response status codes
	typedef enum logic [2:0] {
		ST_DONE       = 3'd0,
		ST_PRINT_CHAR = 3'd1,
		ST_PRINT_NUM  = 3'd2,
		ST_HALTED     = 3'd3,
		ST_FAULT      = 3'd4
	} status_e;

	// machine instruction words
	typedef enum logic [3:0] {
		INS_HALT       = 4'd0,
		INS_ADD        = 4'd1,
		INS_MUL        = 4'd2,
		INS_LT         = 4'd3,
		INS_EQ         = 4'd4,
		INS_JMP        = 4'd5,
		INS_JNZ        = 4'd6,
		INS_COPY       = 4'd7,
		INS_PRINT_CHAR = 4'd8,
		INS_PRINT_NUM  = 4'd9
	} ins_e;
	localparam int INS_COUNT = 10;

	// channel payloads
	typedef struct packed {
		logic [1:0]              opcode;
		logic [CMD_ADDR_W-1:0]   address;
		logic signed [OUT_W-1:0] data;
	} cmd_t;

	typedef struct packed {
		logic [2:0]              status;
		logic signed [OUT_W-1:0] value;
		logic signed [OUT_W-1:0] read_data;
	} rsp_t;

	// microprogram addresses
	typedef enum logic [4:0] {
		U_EXEC0  = 5'd0,
		U_EXEC1  = 5'd1,
		U_EXEC2  = 5'd2,
		U_BIN0   = 5'd3,
		U_BIN1   = 5'd4,
		U_BIN2   = 5'd5,
		U_BIN3   = 5'd6,
		U_MUL0   = 5'd7,
		U_MUL1   = 5'd8,
		U_MUL2   = 5'd9,
		U_JMP    = 5'd10,
		U_JNZ0   = 5'd11,
		U_JNZ1   = 5'd12,
		U_JNZ2   = 5'd13,
		U_JNZ3   = 5'd14,
		U_COPY0  = 5'd15,
		U_COPY1  = 5'd16,
		U_PRINT  = 5'd17,
		U_HALT   = 5'd18,
		U_BAD    = 5'd19,
		U_FAULT  = 5'd20,
		U_WRITE  = 5'd21,
		U_READ0  = 5'd22,
		U_READ1  = 5'd23,
		U_NOP    = 5'd24
	} upc_e;

	// control word fields
	typedef enum logic [1:0] {AS_PC, AS_PTR, AS_ITEM} addr_sel_e;
	typedef enum logic {WD_ITEM, WD_ALU} wd_sel_e;
	typedef enum logic [1:0] {MUL_NONE, MUL_LL, MUL_LH, MUL_HL} mul_e;
	typedef enum logic [1:0] {PC_HOLD, PC_ADV, PC_LOAD} pc_e;
	typedef enum logic [2:0] {
		SEQ_NEXT, SEQ_JUMP, SEQ_DISPATCH, SEQ_IF_MUL, SEQ_IF_AZERO, SEQ_DONE
	} seq_e;
	typedef enum logic [1:0] {SS_DONE, SS_PRINT, SS_HALT, SS_FAULT} st_sel_e;
	typedef enum logic [1:0] {OS_NONE, OS_VALUE, OS_READ} out_sel_e;

	typedef struct packed {
		addr_sel_e  addr_sel;
		logic [1:0] off;
		logic       rd;
		logic       wr;
		wd_sel_e    wd_sel;
		logic       ld_op;
		logic       ld_a;
		logic       ld_b;
		mul_e       mul;
		pc_e        pc_op;
		logic [2:0] len;
		logic       set_fault;
		seq_e       seq;
		upc_e       target;
		st_sel_e    st_sel;
		out_sel_e   out_sel;
	} uword_t;

	// first step of the program for each request opcode
	function automatic upc_e entry_upc(logic [1:0] opcode);
		upc_e u;
		unique case (cmd_op_e'(opcode))
			CMD_WRITE: u = U_WRITE;
			CMD_STEP:  u = U_EXEC0;
			CMD_READ:  u = U_READ0;
			CMD_NOP:   u = U_NOP;
			default:   u = U_NOP;
		endcase
		return u;
	endfunction

	// microcode store, one control word per step
	function automatic uword_t ucode(upc_e u);
		uword_t w;
		w = '0;
		unique case (u)
			// fetch instruction word, then its first pointer
			U_EXEC0: begin
				w.addr_sel = AS_PC; w.off = 2'd0; w.rd = 1'b1;
			end
			U_EXEC1: begin
				w.ld_op = 1'b1; w.addr_sel = AS_PC; w.off = 2'd1; w.rd = 1'b1;
			end
			// first operand read goes out while the instruction is decoded
			U_EXEC2: begin
				w.addr_sel = AS_PTR; w.rd = 1'b1; w.seq = SEQ_DISPATCH;
			end
			// two-operand instructions
			U_BIN0: begin
				w.ld_a = 1'b1; w.addr_sel = AS_PC; w.off = 2'd2; w.rd = 1'b1;
			end
			U_BIN1: begin
				w.addr_sel = AS_PTR; w.rd = 1'b1;
			end
			U_BIN2: begin
				w.ld_b = 1'b1; w.addr_sel = AS_PC; w.off = 2'd3; w.rd = 1'b1;
				w.seq = SEQ_IF_MUL; w.target = U_MUL0;
			end
			U_BIN3: begin
				w.addr_sel = AS_PTR; w.wr = 1'b1; w.wd_sel = WD_ALU;
				w.pc_op = PC_ADV; w.len = 3'd4; w.seq = SEQ_DONE;
			end
			// partial products for the wrapped product
			U_MUL0: begin
				w.mul = MUL_LL;
			end
			U_MUL1: begin
				w.mul = MUL_LH;
			end
			U_MUL2: begin
				w.mul = MUL_HL; w.seq = SEQ_JUMP; w.target = U_BIN3;
			end
			// jumps
			U_JMP: begin
				w.pc_op = PC_LOAD; w.seq = SEQ_DONE;
			end
			U_JNZ0: begin
				w.ld_a = 1'b1; w.addr_sel = AS_PC; w.off = 2'd2; w.rd = 1'b1;
			end
			U_JNZ1: begin
				w.addr_sel = AS_PTR; w.rd = 1'b1;
				w.seq = SEQ_IF_AZERO; w.target = U_JNZ3;
			end
			U_JNZ2: begin
				w.pc_op = PC_LOAD; w.seq = SEQ_DONE;
			end
			U_JNZ3: begin
				w.pc_op = PC_ADV; w.len = 3'd3; w.seq = SEQ_DONE;
			end
			// copy
			U_COPY0: begin
				w.ld_a = 1'b1; w.addr_sel = AS_PC; w.off = 2'd2; w.rd = 1'b1;
			end
			U_COPY1: begin
				w.addr_sel = AS_PTR; w.wr = 1'b1; w.wd_sel = WD_ALU;
				w.pc_op = PC_ADV; w.len = 3'd3; w.seq = SEQ_DONE;
			end
			// print character or number
			U_PRINT: begin
				w.pc_op = PC_ADV; w.len = 3'd2; w.seq = SEQ_DONE;
				w.st_sel = SS_PRINT; w.out_sel = OS_VALUE;
			end
			U_HALT: begin
				w.seq = SEQ_DONE; w.st_sel = SS_HALT;
			end
			U_BAD: begin
				w.set_fault = 1'b1; w.seq = SEQ_DONE; w.st_sel = SS_FAULT;
			end
			U_FAULT: begin
				w.seq = SEQ_DONE; w.st_sel = SS_FAULT;
			end
			// host access to the store
			U_WRITE: begin
				w.addr_sel = AS_ITEM; w.wr = 1'b1; w.wd_sel = WD_ITEM; w.seq = SEQ_DONE;
			end
			U_READ0: begin
				w.addr_sel = AS_ITEM; w.rd = 1'b1;
			end
			U_READ1: begin
				w.seq = SEQ_DONE; w.out_sel = OS_READ;
			end
			U_NOP: begin
				w.seq = SEQ_DONE;
			end
			default: begin
				w.seq = SEQ_DONE;
			end
		endcase
		return w;
	endfunction

endpackage

// ===== rtl/core/tmi_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmi_ram
// Single-port word store with registered read data.
// ----------------------------------------------------------------------------
module tmi_ram #(
	parameter int DEPTH = tmi_pkg::MEM_DEPTH_DEF,
	parameter int WIDTH = tmi_pkg::WORD_WIDTH_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// one access per cycle, read data held until the next read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/tape_machine_interpreter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tape_machine_interpreter_top
// Stored-program machine with memory-indirect operands, run by a microcoded
// sequencer over a single-port word store.
// ----------------------------------------------------------------------------
// Usage
// - cmd channel: one request writes a word, steps one instruction, reads a
//   word or does nothing (no-op). It is taken when cmd_valid is high and cmd_stall is low.
// - rsp channel: exactly one response per request, in request order, held in
//   an output register while rsp_stall is high.
// - one request is worked on at a time; the next can be taken while the last
//   response still waits. The next request can be taken in the same cycle as
//   the response is offered. The single memory port allows one access per
//   microstep.
// - a stalled response holds the sequencer at its final step, with no store
//   or program counter update, until the output register frees up.
// - after reset the store is swept to zero, one word per cycle, with cmd_stall
//   high. Program counter and fault flag reset to zero.
// - MEM_DEPTH must be a power of two (the block does not enforce it); addresses wrap modulo the depth.
// ----------------------------------------------------------------------------
module tape_machine_interpreter_top #(
	parameter int MEM_DEPTH  = tmi_pkg::MEM_DEPTH_DEF,
	parameter int WORD_WIDTH = tmi_pkg::WORD_WIDTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_stall,
	input  tmi_pkg::cmd_t cmd,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output tmi_pkg::rsp_t rsp
);

	localparam int ADDR_W = $clog2(MEM_DEPTH);

	// control state
	logic                 clr_q;
	logic [ADDR_W-1:0]    clr_cnt_q;
	logic                 busy_q;
	tmi_pkg::upc_e        upc_q;
	logic [ADDR_W-1:0]    pc_q;
	logic                 fault_q;
	logic                 rsp_valid_q;

	// payload state
	tmi_pkg::cmd_t        item_q;
	logic [WORD_WIDTH-1:0] op_q;
	logic [WORD_WIDTH-1:0] a_q;
	logic [WORD_WIDTH-1:0] b_q;
	logic [tmi_pkg::PROD_W-1:0] mul_q;
	logic [tmi_pkg::PROD_W-1:0] acc_q;
	tmi_pkg::rsp_t        rsp_q;

	// combinational
	tmi_pkg::uword_t      uw;
	logic                 cmd_acc;
	logic                 step_en;
	logic                 hold_done;
	tmi_pkg::upc_e        upc_next;
	tmi_pkg::upc_e        upc_disp;
	tmi_pkg::ins_e        ins;
	logic                 op_known;
	logic                 mem_we;
	logic                 mem_re;
	logic [ADDR_W-1:0]    mem_addr;
	logic [WORD_WIDTH-1:0] mem_wdata;
	logic [WORD_WIDTH-1:0] rd_data;
	logic [ADDR_W-1:0]    ptr;
	logic [WORD_WIDTH-1:0] alu_res;
	logic [tmi_pkg::PROD_W-1:0] a_ext;
	logic [tmi_pkg::PROD_W-1:0] b_ext;
	logic [tmi_pkg::MUL_W-1:0]  mul_x;
	logic [tmi_pkg::MUL_W-1:0]  mul_y;
	logic [tmi_pkg::PROD_W-1:0] mul_p;
	logic [tmi_pkg::OUT_W-1:0]  word_out;
	tmi_pkg::status_e     status;

	// word store
	tmi_ram #(
		.DEPTH (MEM_DEPTH),
		.WIDTH (WORD_WIDTH)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.re    (mem_re),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (rd_data)
	);

	// microcode and handshake
	assign uw        = tmi_pkg::ucode(upc_q);
	assign cmd_stall = busy_q | clr_q;
	assign cmd_acc   = cmd_valid & ~cmd_stall;
	assign hold_done = (uw.seq == tmi_pkg::SEQ_DONE) & rsp_valid_q & rsp_stall;
	assign step_en   = busy_q & ~hold_done;

	// instruction decode, anything outside the set is unknown
	assign ins      = tmi_pkg::ins_e'(op_q[3:0]);
	assign op_known = op_q < WORD_WIDTH'(tmi_pkg::INS_COUNT);
	assign ptr      = rd_data[ADDR_W-1:0];

	// memory port: clearing sweep, else the current microstep
	always_comb begin
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_addr  = pc_q + ADDR_W'(uw.off);
		mem_wdata = alu_res;
		if (clr_q) begin
			mem_we    = 1'b1;
			mem_addr  = clr_cnt_q;
			mem_wdata = '0;
		end else begin
			mem_we = step_en & uw.wr;
			mem_re = step_en & uw.rd;
			case (uw.addr_sel)
				tmi_pkg::AS_PTR:  mem_addr = ptr;
				tmi_pkg::AS_ITEM: mem_addr = ADDR_W'(item_q.address);
				default:          mem_addr = pc_q + ADDR_W'(uw.off);
			endcase
			if (uw.wd_sel == tmi_pkg::WD_ITEM) begin
				mem_wdata = WORD_WIDTH'(item_q.data);
			end
		end
	end

	// shared 32 x 32 multiplier over zero-extended halves
	assign a_ext = tmi_pkg::PROD_W'(a_q);
	assign b_ext = tmi_pkg::PROD_W'(b_q);
	assign mul_x = (uw.mul == tmi_pkg::MUL_HL) ? a_ext[tmi_pkg::PROD_W-1:tmi_pkg::MUL_W]
	                                           : a_ext[tmi_pkg::MUL_W-1:0];
	assign mul_y = (uw.mul == tmi_pkg::MUL_LH) ? b_ext[tmi_pkg::PROD_W-1:tmi_pkg::MUL_W]
	                                           : b_ext[tmi_pkg::MUL_W-1:0];
	assign mul_p = tmi_pkg::PROD_W'(mul_x) * tmi_pkg::PROD_W'(mul_y);

	// result word for the store
	always_comb begin
		case (ins)
			tmi_pkg::INS_ADD: alu_res = a_q + b_q;
			tmi_pkg::INS_MUL: alu_res = WORD_WIDTH'(acc_q + (mul_q << tmi_pkg::MUL_W));
			tmi_pkg::INS_LT:  alu_res = WORD_WIDTH'($signed(a_q) < $signed(b_q));
			tmi_pkg::INS_EQ:  alu_res = WORD_WIDTH'(a_q == b_q);
			default:          alu_res = a_q;
		endcase
	end

	// instruction dispatch
	always_comb begin
		upc_disp = tmi_pkg::U_BAD;
		if (fault_q) begin
			upc_disp = tmi_pkg::U_FAULT;
		end else if (op_known) begin
			case (ins) inside
				tmi_pkg::INS_HALT:
					upc_disp = tmi_pkg::U_HALT;
				tmi_pkg::INS_ADD, tmi_pkg::INS_MUL, tmi_pkg::INS_LT, tmi_pkg::INS_EQ:
					upc_disp = tmi_pkg::U_BIN0;
				tmi_pkg::INS_JMP:
					upc_disp = tmi_pkg::U_JMP;
				tmi_pkg::INS_JNZ:
					upc_disp = tmi_pkg::U_JNZ0;
				tmi_pkg::INS_COPY:
					upc_disp = tmi_pkg::U_COPY0;
				tmi_pkg::INS_PRINT_CHAR, tmi_pkg::INS_PRINT_NUM:
					upc_disp = tmi_pkg::U_PRINT;
				default:
					upc_disp = tmi_pkg::U_BAD;
			endcase
		end
	end

	// step counter sequencing
	always_comb begin
		unique case (uw.seq)
			tmi_pkg::SEQ_JUMP:     upc_next = uw.target;
			tmi_pkg::SEQ_DISPATCH: upc_next = upc_disp;
			tmi_pkg::SEQ_IF_MUL:   upc_next = (ins == tmi_pkg::INS_MUL) ? uw.target
			                                  : tmi_pkg::upc_e'(upc_q + 1'b1);
			tmi_pkg::SEQ_IF_AZERO: upc_next = (a_q == '0) ? uw.target
			                                  : tmi_pkg::upc_e'(upc_q + 1'b1);
			tmi_pkg::SEQ_DONE:     upc_next = upc_q;
			default:               upc_next = tmi_pkg::upc_e'(upc_q + 1'b1);
		endcase
	end

	// response fields
	assign word_out = tmi_pkg::OUT_W'($signed(rd_data));
	always_comb begin
		unique case (uw.st_sel)
			tmi_pkg::SS_PRINT: status = (ins == tmi_pkg::INS_PRINT_NUM) ?
			                            tmi_pkg::ST_PRINT_NUM : tmi_pkg::ST_PRINT_CHAR;
			tmi_pkg::SS_HALT:  status = tmi_pkg::ST_HALTED;
			tmi_pkg::SS_FAULT: status = tmi_pkg::ST_FAULT;
			default:           status = tmi_pkg::ST_DONE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= 1'b1;
			clr_cnt_q   <= '0;
			busy_q      <= 1'b0;
			upc_q       <= tmi_pkg::U_NOP;
			pc_q        <= '0;
			fault_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			// clearing sweep after reset
			if (clr_q) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
				if (clr_cnt_q == ADDR_W'(MEM_DEPTH - 1)) begin
					clr_q <= 1'b0;
				end
			end
			// sequencer
			if (cmd_acc) begin
				busy_q <= 1'b1;
				upc_q  <= tmi_pkg::entry_upc(cmd.opcode);
			end else if (step_en) begin
				upc_q <= upc_next;
				if (uw.seq == tmi_pkg::SEQ_DONE) begin
					busy_q <= 1'b0;
				end
				if (uw.set_fault) begin
					fault_q <= 1'b1;
				end
				case (uw.pc_op)
					tmi_pkg::PC_ADV:  pc_q <= pc_q + ADDR_W'(uw.len);
					tmi_pkg::PC_LOAD: pc_q <= ptr;
					default:          pc_q <= pc_q;
				endcase
			end
			// output register
			if (step_en && uw.seq == tmi_pkg::SEQ_DONE) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			item_q <= cmd;
		end
		if (step_en) begin
			if (uw.ld_op) begin
				op_q <= rd_data;
			end
			if (uw.ld_a) begin
				a_q <= rd_data;
			end
			if (uw.ld_b) begin
				b_q <= rd_data;
			end
			case (uw.mul)
				tmi_pkg::MUL_LL: begin
					mul_q <= mul_p;
				end
				tmi_pkg::MUL_LH: begin
					acc_q <= mul_q;
					mul_q <= mul_p;
				end
				tmi_pkg::MUL_HL: begin
					acc_q <= acc_q + (mul_q << tmi_pkg::MUL_W);
					mul_q <= mul_p;
				end
				default: begin
					mul_q <= mul_q;
				end
			endcase
			if (uw.seq == tmi_pkg::SEQ_DONE) begin
				rsp_q.status    <= status;
				rsp_q.value     <= (uw.out_sel == tmi_pkg::OS_VALUE) ? word_out : '0;
				rsp_q.read_data <= (uw.out_sel == tmi_pkg::OS_READ) ? word_out : '0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== rtl/core/tmi_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmi_checker
// Port-level checks of the interpreter: request and response accounting, print value and hold.
// ----------------------------------------------------------------------------
module tmi_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          cmd_valid,
	input logic          cmd_stall,
	input tmi_pkg::cmd_t cmd,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input tmi_pkg::rsp_t rsp
);

	logic [1:0] pend_q;
	logic       cmd_acc;
	logic       rsp_acc;

	assign cmd_acc = cmd_valid & ~cmd_stall;
	assign rsp_acc = rsp_valid & ~rsp_stall;

	// requests taken but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + {1'b0, cmd_acc} - {1'b0, rsp_acc};
		end
	end

	// no response without an open request
	a_rsp_has_req: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> pend_q != 2'd0)
		else $error("response without an open request");

	// one request in work and one waiting response at most
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q == 2'd2 |-> cmd_stall)
		else $error("request taken while two are open");

	// value is zero unless something was printed
	a_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != tmi_pkg::ST_PRINT_CHAR &&
		rsp.status != tmi_pkg::ST_PRINT_NUM |-> rsp.value == '0)
		else $error("value set on a response without print");

	// stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled response changed");

	// stalled request holds
	a_cmd_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_stall |=> cmd_valid && $stable(cmd))
		else $error("stalled request changed");

endmodule

bind tape_machine_interpreter_top tmi_checker u_tmi_checker (.*);
